// ===== src/cal_pkg.sv =====
// Shared types and codes for the compacting array list.
// Used by cal_ctrl, cal_dpath and compacting_array_list; no dependencies.
package cal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 6;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE_POS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_VAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        [KIND_W-1:0] kind;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   read_value;
    logic        [COUNT_W-1:0]  count;
    logic        [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                load;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                idx_load_pos;
    logic                idx_clear;
    logic                idx_inc;
    logic                rd_pos;
    logic                rd_next;
    logic                rd_capture;
    logic                wr_append;
    logic                wr_shift;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                cnt_clear;
    logic                res_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pos_err;
    logic              full;
    logic              empty;
    logic              last;
    logic              match;
    logic              out_free;
  } sts_t;

endpackage

// ===== src/cal_ctrl.sv =====
// Request sequencer for the compacting array list.
// Depends on cal_pkg; drives cal_dpath through cmd_t and reads sts_t.
module cal_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cal_pkg::sts_t sts,
  output cal_pkg::cmd_t cmd
);
  import cal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (sts.kind)
          KIND_REMOVE_POS: state_next = sts.pos_err ? S_DONE : S_SHIFT_RD;
          KIND_REMOVE_VAL: state_next = sts.empty ? S_DONE : S_SCAN_RD;
          KIND_READ:       state_next = sts.pos_err ? S_DONE : S_READ_WAIT;
          default:         state_next = S_DONE;
        endcase
      end
      S_READ_WAIT: state_next = S_DONE;
      S_SCAN_RD:   state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts.match) begin
          state_next = S_SHIFT_RD;
        end else if (sts.last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_next = sts.last ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load        = req_valid;
      end
      S_EXEC: begin
        case (sts.kind)
          KIND_APPEND: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
          end
          KIND_REMOVE_POS: begin
            if (sts.pos_err) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.idx_load_pos = 1'b1;
            end
          end
          KIND_REMOVE_VAL: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
            end else begin
              cmd.idx_clear = 1'b1;
            end
          end
          KIND_READ: begin
            if (sts.pos_err) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.rd_pos = 1'b1;
            end
          end
          KIND_CLEAR: cmd.cnt_clear = 1'b1;
          default: ;
        endcase
      end
      S_READ_WAIT: cmd.rd_capture = 1'b1;
      S_SCAN_CMP: begin
        if (!sts.match) begin
          if (sts.last) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOT_FOUND;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SHIFT_RD: begin
        if (sts.last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_DONE: cmd.res_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/cal_dpath.sv =====
// Entry memory, count, scan index and result register of the compacting array list.
// Depends on cal_pkg; controlled by cal_ctrl through cmd_t.
module cal_dpath #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cal_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cal_pkg::rsp_t rsp,
  input  cal_pkg::cmd_t cmd,
  output cal_pkg::sts_t sts
);
  import cal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] rd_val;
  logic [STATUS_W-1:0]      status;
  req_t                     op;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            idx_p1;
  logic [AW-1:0]            rd_addr;

  assign idx_p1 = idx + CW'(1);

  always_comb begin
    if (cmd.rd_pos) begin
      rd_addr = AW'(op.position);
    end else if (cmd.rd_next) begin
      rd_addr = idx_p1[AW-1:0];
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.wr_append) begin
      mem[count[AW-1:0]] <= op.value;
    end else if (cmd.wr_shift) begin
      mem[idx[AW-1:0]] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= req;
      rd_val <= '0;
      status <= ST_OK;
    end else begin
      if (cmd.rd_capture) rd_val <= rdata;
      if (cmd.set_status) status <= cmd.status_code;
    end
    if (cmd.idx_load_pos) begin
      idx <= CW'(op.position);
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1;
    end
    if (cmd.res_load) begin
      rsp.read_value <= rd_val;
      rsp.count      <= COUNT_W'(count);
      rsp.status     <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.kind     = op.kind;
  assign sts.pos_err  = (|(op.position >> CW)) || (CW'(op.position) >= count);
  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.empty    = (count == '0);
  assign sts.last     = (idx_p1 >= count);
  assign sts.match    = (rdata == op.value);
  assign sts.out_free = !rsp_valid || !rsp_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full)
    else $error("append into a full table");

  a_res_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free)
    else $error("result register overwritten while held");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !sts.empty)
    else $error("remove from an empty table");

endmodule

// ===== src/compacting_array_list.sv =====
// Top level of the compacting array list: an ordered, gap-free list of signed
// 32-bit values held in a single-port-write memory of CAPACITY entries.
// Each request item gives one response item. From acceptance, append, clear,
// unused kinds, failed reads and failed removes at a position go from the
// execute state straight to the done state; a read passes through a read-wait
// state to capture the registered memory output; a remove at a position walks
// from that position to the end, reading the next entry and writing it one slot
// down, then decrements the count; a remove by value first scans from entry 0,
// reading and comparing each entry until a match starts the same shift or the
// last entry ends it with not-found. Removal moves entries through the memory's
// registered read port. One request is in flight at a time and the next one is
// taken in the cycle after the response is loaded; a held response that is
// still stalled keeps the block from finishing the next request. A new request
// is taken while the previous response still waits in the output register. The
// input is stalled during reset. No clearing pass after reset.
module compacting_array_list #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cal_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cal_pkg::rsp_t rsp
);
  import cal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
